// ----- hdl/e2c_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_pkg: shared types, constants and calendar helpers
// Holds the result record, the second counts used by the sequencer and the
// small calendar tables for the epoch to calendar converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

  // Width of the shared adder and of the working accumulator.
  localparam int unsigned AccW = 34;

  // Seconds per common and leap year, per day, hour and minute; days per week.
  localparam logic [AccW-1:0] YEAR_SECS      = 34'd31536000;
  localparam logic [AccW-1:0] LEAP_YEAR_SECS = 34'd31622400;
  localparam logic [AccW-1:0] DAY_SECS       = 34'd86400;
  localparam logic [AccW-1:0] HOUR_SECS      = 34'd3600;
  localparam logic [AccW-1:0] MIN_SECS       = 34'd60;
  localparam logic [AccW-1:0] WEEK_DAYS      = 34'd7;

  // Start year as an offset from 1900, and the weekday of its January first.
  localparam logic [7:0] BASE_YEAR_OFS = 8'd70;
  localparam logic [2:0] BASE_WEEKDAY  = 3'd4;   // Thursday

  // Restoring division start bits (quotient widths minus one).
  localparam logic [3:0] DAY_TOP_BIT  = 4'd8;
  localparam logic [3:0] HOUR_TOP_BIT = 4'd4;
  localparam logic [3:0] MIN_TOP_BIT  = 4'd5;
  localparam logic [3:0] WEEK_TOP_BIT = 4'd5;

  localparam logic [3:0] LAST_MONTH = 4'd11;
  localparam logic [3:0] FEBRUARY   = 4'd1;

  // One result record; the last field sits in the lowest bits.
  typedef struct packed {
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } result_t;

  // Gregorian rule over 1901..2038: every fourth year, 1900 itself excluded.
  function automatic logic is_leap(input logic [7:0] year_ofs);
    return (year_ofs[1:0] == 2'd0) && (year_ofs != 8'd0);
  endfunction

  // Length of a month in days.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      FEBRUARY:                                  len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/e2c_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_alu: shared add/subtract unit
// One signed adder used by every step of the sequencer; it reports whether
// the result went negative, which drives all compare decisions.
// ----------------------------------------------------------------------------
module e2c_alu (
  input  wire logic signed [e2c_pkg::AccW-1:0] a,
  input  wire logic        [e2c_pkg::AccW-1:0] b,
  input  wire logic                            sub,
  output logic      signed [e2c_pkg::AccW-1:0] sum,
  output logic                                 neg
);

  // Add or subtract the operand, then take the sign of the result.
  always_comb begin
    if (sub) begin
      sum = a - $signed(b);
    end else begin
      sum = a + $signed(b);
    end
    neg = sum[e2c_pkg::AccW-1];
  end

endmodule
`default_nettype wire

// ----- hdl/e2c_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_core: calendar conversion sequencer
// Steps whole years from 1970, splits the remainder into days, hours,
// minutes and seconds by restoring division, steps months and finds the
// weekday, all through one shared adder.
// ----------------------------------------------------------------------------
module e2c_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [31:0]     epoch_seconds,
  input  wire logic                   res_ack,
  output logic                        idle,
  output logic                        res_valid,
  output e2c_pkg::result_t            result
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_YFWD, ST_YBWD, ST_DDAY, ST_DHOUR, ST_DMIN, ST_MONTH, ST_DWEEK, ST_DONE
  } state_t;

  state_t                             state;
  logic signed [e2c_pkg::AccW-1:0]    acc;
  logic [7:0]                         year;
  logic [2:0]                         wd_jan1;
  logic [3:0]                         step;
  logic [8:0]                         quo;
  logic [8:0]                         yday;
  logic [4:0]                         hour;
  logic [5:0]                         minute;
  logic [5:0]                         second;
  logic [3:0]                         month;
  logic [4:0]                         dom;
  logic [2:0]                         weekday;

  logic [e2c_pkg::AccW-1:0]           alu_b;
  logic                               alu_sub;
  logic signed [e2c_pkg::AccW-1:0]    alu_sum;
  logic                               alu_neg;
  logic                               fits;
  logic [7:0]                         year_prev;
  logic                               leap_cur;
  logic                               leap_prev;
  logic [8:0]                         quo_next;
  logic [2:0]                         rem7;
  logic [3:0]                         wsum;
  logic [2:0]                         weekday_next;

  // Advance or retreat the January-first weekday by one year.
  function automatic logic [2:0] wd_fwd(input logic [2:0] wd, input logic leap);
    logic [3:0] s;
    s = {1'b0, wd} + (leap ? 4'd2 : 4'd1);
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

  function automatic logic [2:0] wd_bwd(input logic [2:0] wd, input logic leap);
    logic [3:0] s;
    s = {1'b0, wd} + (leap ? 4'd5 : 4'd6);
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

  e2c_alu u_alu (
    .a   (acc),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  assign year_prev = year - 8'd1;
  assign leap_cur  = e2c_pkg::is_leap(year);
  assign leap_prev = e2c_pkg::is_leap(year_prev);
  assign fits      = !alu_neg;
  assign quo_next  = quo | (fits ? (9'd1 << step) : 9'd0);

  // Operand selection for the shared adder.
  always_comb begin
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state)
      ST_YFWD:  alu_b = leap_cur ? e2c_pkg::LEAP_YEAR_SECS : e2c_pkg::YEAR_SECS;
      ST_YBWD: begin
        alu_sub = 1'b0;
        alu_b   = leap_prev ? e2c_pkg::LEAP_YEAR_SECS : e2c_pkg::YEAR_SECS;
      end
      ST_DDAY:  alu_b = e2c_pkg::DAY_SECS << step;
      ST_DHOUR: alu_b = e2c_pkg::HOUR_SECS << step;
      ST_DMIN:  alu_b = e2c_pkg::MIN_SECS << step;
      ST_DWEEK: alu_b = e2c_pkg::WEEK_DAYS << step;
      ST_MONTH: alu_b = e2c_pkg::AccW'(e2c_pkg::month_days(month, leap_cur));
      default:  alu_b = '0;
    endcase
  end

  // Weekday from the January-first weekday and the day of year modulo seven.
  always_comb begin
    rem7         = fits ? alu_sum[2:0] : acc[2:0];
    wsum         = {1'b0, wd_jan1} + {1'b0, rem7};
    weekday_next = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
  end

  // Sequencer state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            acc     <= e2c_pkg::AccW'(epoch_seconds);
            year    <= e2c_pkg::BASE_YEAR_OFS;
            wd_jan1 <= e2c_pkg::BASE_WEEKDAY;
            state   <= epoch_seconds[31] ? ST_YBWD : ST_YFWD;
          end
        end
        ST_YFWD: begin
          if (fits) begin
            acc     <= alu_sum;
            year    <= year + 8'd1;
            wd_jan1 <= wd_fwd(wd_jan1, leap_cur);
          end else begin
            step  <= e2c_pkg::DAY_TOP_BIT;
            quo   <= '0;
            state <= ST_DDAY;
          end
        end
        ST_YBWD: begin
          acc     <= alu_sum;
          year    <= year_prev;
          wd_jan1 <= wd_bwd(wd_jan1, leap_prev);
          if (fits) begin
            step  <= e2c_pkg::DAY_TOP_BIT;
            quo   <= '0;
            state <= ST_DDAY;
          end
        end
        ST_DDAY: begin
          if (fits) acc <= alu_sum;
          if (step == 4'd0) begin
            yday  <= quo_next;
            quo   <= '0;
            step  <= e2c_pkg::HOUR_TOP_BIT;
            state <= ST_DHOUR;
          end else begin
            quo  <= quo_next;
            step <= step - 4'd1;
          end
        end
        ST_DHOUR: begin
          if (fits) acc <= alu_sum;
          if (step == 4'd0) begin
            hour  <= quo_next[4:0];
            quo   <= '0;
            step  <= e2c_pkg::MIN_TOP_BIT;
            state <= ST_DMIN;
          end else begin
            quo  <= quo_next;
            step <= step - 4'd1;
          end
        end
        ST_DMIN: begin
          if (step == 4'd0) begin
            minute <= quo_next[5:0];
            second <= fits ? alu_sum[5:0] : acc[5:0];
            acc    <= e2c_pkg::AccW'(yday);
            month  <= '0;
            state  <= ST_MONTH;
          end else begin
            if (fits) acc <= alu_sum;
            quo  <= quo_next;
            step <= step - 4'd1;
          end
        end
        ST_MONTH: begin
          // December keeps whatever days are left.
          if (month != e2c_pkg::LAST_MONTH && fits) begin
            acc   <= alu_sum;
            month <= month + 4'd1;
          end else begin
            dom   <= acc[4:0] + 5'd1;
            acc   <= e2c_pkg::AccW'(yday);
            step  <= e2c_pkg::WEEK_TOP_BIT;
            state <= ST_DWEEK;
          end
        end
        ST_DWEEK: begin
          if (fits) acc <= alu_sum;
          if (step == 4'd0) begin
            weekday <= weekday_next;
            state   <= ST_DONE;
          end else begin
            step <= step - 4'd1;
          end
        end
        ST_DONE: begin
          if (res_ack) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    result.second           = second;
    result.minute           = minute;
    result.hour             = hour;
    result.day_of_month     = dom;
    result.month_index      = month;
    result.years_since_1900 = year;
    result.day_of_year      = yday;
    result.weekday          = weekday;
  end

endmodule
`default_nettype wire

// ----- hdl/epoch_to_calendar.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_to_calendar: Unix seconds to broken-down UTC calendar time
// Accepts one signed 32-bit epoch count and returns second, minute, hour,
// day of month, month, year, day of year and weekday through an output
// register so a waiting result does not block the next input.
// ----------------------------------------------------------------------------
// From the accepting edge to the output register the sequencer steps one whole
// year at a time from 1970, then runs 9 + 5 + 6 division steps, 1 to 12 month
// steps, 6 weekday steps and a hand-off to the output register.
// Input is ready only while the sequencer is idle, so a new epoch count is taken
// only after the last result has been handed off. Reset (rst, synchronous) empties
// the output register and returns the sequencer to idle.
module epoch_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] epoch_seconds
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                      // [21:17] day_of_month, [25:22] month_index,
                                      // [33:26] years_since_1900, [42:34] day_of_year,
                                      // [45:43] weekday, [47:46] zero
);

  logic              core_idle;
  logic              res_valid;
  logic              res_ack;
  e2c_pkg::result_t  core_result;
  e2c_pkg::result_t  out_reg;

  assign s_tready = core_idle;

  e2c_core u_core (
    .clk           (clk),
    .rst           (rst),
    .start         (s_tvalid && core_idle),
    .epoch_seconds ($signed(s_tdata)),
    .res_ack       (res_ack),
    .idle          (core_idle),
    .res_valid     (res_valid),
    .result        (core_result)
  );

  // Load the output register whenever it is empty or being drained.
  assign res_ack = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_ack) begin
        m_tvalid <= 1'b1;
        out_reg  <= core_result;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {2'b00, out_reg};

endmodule
`default_nettype wire
